// File: rtl/cycling_power_packet_parser_top_defines.svh
// Assertion macros for the cycling power parser top level.
`ifndef CYCLING_POWER_PACKET_PARSER_TOP_DEFINES_SVH
`define CYCLING_POWER_PACKET_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define CPP_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("cpp: implication check failed");
// Next-cycle implication, disabled while in reset.
`define CPP_ASSERT_NXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("cpp: next-cycle check failed");
`else
`define CPP_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons)
`define CPP_ASSERT_NXT(lbl, clk_sig, rstn_sig, ante, cons)
`endif

`endif

// File: rtl/cpp_pkg.sv
// Types and constants shared by the cycling power parser modules.
package cpp_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [15:0] FLG_BALANCE = 16'h0001;
    localparam logic [15:0] FLG_CRANK   = 16'h0002;
    localparam logic [15:0] FLG_ANGLES  = 16'h0100;
    localparam logic [15:0] FLG_TOP     = 16'h0200;
    localparam logic [15:0] FLG_BOTTOM  = 16'h0400;

    localparam logic [7:0] BALANCE_DEFAULT = 8'd100;
    localparam logic [7:0] CADENCE_MAX     = 8'd255;

    localparam int OUT_W = 72;

    // One parsed packet, handed from front to back.
    typedef struct packed {
        logic [14:0] power;
        logic [7:0]  balance;
        logic        balance_ok;
        logic        crank_ok;
        logic [15:0] revs;
        logic [15:0] evt_time;
        logic [15:0] top;
        logic        top_ok;
        logic [15:0] bottom;
        logic        bottom_ok;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_st_t;

endpackage

// File: rtl/cpp_front.sv
// Byte collector: captures packet fields by position and classifies the packet.
module cpp_front #(
    parameter int MAX_PACKET_BYTES = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             angles_supported,
    input  logic             byte_valid,
    output logic             byte_ready,
    input  logic [7:0]       byte_data,
    input  logic             byte_last,
    output logic             push,
    output cpp_pkg::rec_t    push_rec,
    input  cpp_pkg::fifo_st_t fifo_st
);
    import cpp_pkg::*;

    localparam int BYTE_CAP = (MAX_PACKET_BYTES < 63) ? MAX_PACKET_BYTES : 63;

    logic [5:0]  byte_count_reg, byte_count_next;
    logic [15:0] flag_word_reg, flag_word_next;
    logic [15:0] power_field_reg, power_field_next;
    logic [7:0]  balance_field_reg, balance_field_next;
    logic [31:0] crank_field_reg, crank_field_next;
    logic [15:0] top_field_reg, top_field_next;
    logic [15:0] bottom_field_reg, bottom_field_next;
    logic        pending_reg, pending_next;

    logic        accept;
    logic [5:0]  pos, crank_pos, top_pos, bot_pos;
    logic [5:0]  crank_idx, top_idx, bot_idx;

    // classification
    logic [5:0]  len, off1, off2, off3;
    logic        bal_ok, crank_ok, ang_en, top_ok, bot_ok;

    assign accept     = byte_valid && byte_ready;
    assign byte_ready = !pending_reg;
    assign push       = pending_reg && !fifo_st.full;

    assign pos       = byte_count_reg;
    assign crank_pos = 6'd4 + {5'd0, flag_word_reg[0]};
    assign top_pos   = crank_pos + ((flag_word_reg & FLG_CRANK) != 16'd0 ? 6'd4 : 6'd0);
    assign bot_pos   = top_pos + ((flag_word_reg & FLG_TOP) != 16'd0 ? 6'd2 : 6'd0);
    assign crank_idx = pos - crank_pos;
    assign top_idx   = pos - top_pos;
    assign bot_idx   = pos - bot_pos;

    always_comb
    begin
        byte_count_next    = byte_count_reg;
        flag_word_next     = flag_word_reg;
        power_field_next   = power_field_reg;
        balance_field_next = balance_field_reg;
        crank_field_next   = crank_field_reg;
        top_field_next     = top_field_reg;
        bottom_field_next  = bottom_field_reg;
        pending_next       = pending_reg;

        if (accept)
        begin
            if (byte_count_reg < 6'(BYTE_CAP))
            begin
                byte_count_next = byte_count_reg + 6'd1;
                if (pos < 6'd2)
                    flag_word_next[8*pos[0] +: 8] = byte_data;
                else if (pos < 6'd4)
                    power_field_next[8*pos[0] +: 8] = byte_data;
                else if (flag_word_reg[0] && pos == 6'd4)
                    balance_field_next = byte_data;
                else
                begin
                    if (pos >= crank_pos && pos < crank_pos + 6'd4)
                        crank_field_next[8*crank_idx[1:0] +: 8] = byte_data;
                    if (pos >= top_pos && pos < top_pos + 6'd2)
                        top_field_next[8*top_idx[0] +: 8] = byte_data;
                    if (pos >= bot_pos && pos < bot_pos + 6'd2)
                        bottom_field_next[8*bot_idx[0] +: 8] = byte_data;
                end
            end
            if (byte_last)
            begin
                // a packet under two bytes is dropped without a result
                if (byte_count_next < 6'd2)
                begin
                    byte_count_next    = '0;
                    flag_word_next     = '0;
                    power_field_next   = '0;
                    balance_field_next = '0;
                    crank_field_next   = '0;
                    top_field_next     = '0;
                    bottom_field_next  = '0;
                end
                else
                    pending_next = 1'b1;
            end
        end
        else if (push)
        begin
            byte_count_next    = '0;
            flag_word_next     = '0;
            power_field_next   = '0;
            balance_field_next = '0;
            crank_field_next   = '0;
            top_field_next     = '0;
            bottom_field_next  = '0;
            pending_next       = 1'b0;
        end
    end

    // Field presence follows the running offset of the fields before it.
    assign len      = byte_count_reg;
    assign bal_ok   = flag_word_reg[0] && (len >= 6'd5);
    assign off1     = bal_ok ? 6'd5 : 6'd4;
    assign crank_ok = ((flag_word_reg & FLG_CRANK) != 16'd0) && (len >= off1 + 6'd4);
    assign off2     = off1 + (crank_ok ? 6'd4 : 6'd0);
    assign ang_en   = angles_supported && ((flag_word_reg & FLG_ANGLES) != 16'd0);
    assign top_ok   = ang_en && ((flag_word_reg & FLG_TOP) != 16'd0) && (len >= off2 + 6'd2);
    assign off3     = off2 + (top_ok ? 6'd2 : 6'd0);
    assign bot_ok   = ang_en && ((flag_word_reg & FLG_BOTTOM) != 16'd0)
                      && (len >= off3 + 6'd2);

    always_comb
    begin
        push_rec.power      = (len >= 6'd4 && !power_field_reg[15]) ? power_field_reg[14:0]
                                                                    : 15'd0;
        push_rec.balance    = bal_ok ? balance_field_reg : BALANCE_DEFAULT;
        push_rec.balance_ok = bal_ok;
        push_rec.crank_ok   = crank_ok;
        push_rec.revs       = crank_field_reg[15:0];
        push_rec.evt_time   = crank_field_reg[31:16];
        push_rec.top        = top_ok ? top_field_reg : 16'd0;
        push_rec.top_ok     = top_ok;
        push_rec.bottom     = bot_ok ? bottom_field_reg : 16'd0;
        push_rec.bottom_ok  = bot_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            flag_word_reg     <= '0;
            power_field_reg   <= '0;
            balance_field_reg <= '0;
            crank_field_reg   <= '0;
            top_field_reg     <= '0;
            bottom_field_reg  <= '0;
            pending_reg       <= 1'b0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            flag_word_reg     <= flag_word_next;
            power_field_reg   <= power_field_next;
            balance_field_reg <= balance_field_next;
            crank_field_reg   <= crank_field_next;
            top_field_reg     <= top_field_next;
            bottom_field_reg  <= bottom_field_next;
            pending_reg       <= pending_next;
        end
    end

endmodule

// File: rtl/cpp_fifo.sv
// Short record queue between the byte collector and the cadence engine.
module cpp_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cpp_pkg::rec_t     push_rec,
    input  logic              pop,
    output cpp_pkg::rec_t     pop_rec,
    output cpp_pkg::fifo_st_t st
);
    import cpp_pkg::*;

    rec_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign st.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign st.empty = (count_reg == '0);
    assign pop_rec  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !st.full)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !st.full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !st.empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            unique case ({push && !st.full, pop && !st.empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/cpp_back.sv
// Cadence engine: crank history, serial divider and the result register.
module cpp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cpp_pkg::fifo_st_t          fifo_st,
    input  cpp_pkg::rec_t              pop_rec,
    output logic                       pop,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [cpp_pkg::OUT_W-1:0]  res_data
);
    import cpp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t      state_reg;
    rec_t        rec_reg;
    logic [15:0] prev_revs_reg, prev_time_reg;
    logic        hist_valid_reg;
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] divisor_reg;
    logic [4:0]  step_reg;
    logic [7:0]  cadence_reg;
    logic        res_valid_reg;
    logic [OUT_W-1:0] res_data_reg;

    logic [15:0] d_revs, d_time;
    logic [19:0] revs_x15;
    logic [16:0] trial;
    logic        fits;
    logic        out_free;

    assign pop      = (state_reg == ST_IDLE) && !fifo_st.empty;
    assign d_revs   = pop_rec.revs - prev_revs_reg;
    assign d_time   = pop_rec.evt_time - prev_time_reg;
    // 61440 = 15 * 4096
    assign revs_x15 = {d_revs, 4'd0} - {4'd0, d_revs};

    // restoring divide, one quotient bit a cycle
    assign trial    = {rem_reg[15:0], quo_reg[31]};
    assign fits     = trial >= {1'b0, divisor_reg};
    assign rem_next = fits ? trial - {1'b0, divisor_reg} : trial;
    assign quo_next = {quo_reg[30:0], fits};

    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_revs_reg  <= '0;
            prev_time_reg  <= '0;
            hist_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            // in ST_DONE the output load below decides the valid flag
            if (res_valid_reg && res_ready && state_reg != ST_DONE)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        rec_reg     <= pop_rec;
                        cadence_reg <= 8'd0;
                        if (pop_rec.crank_ok && hist_valid_reg &&
                            d_revs != 16'd0 && d_time != 16'd0)
                        begin
                            quo_reg     <= {revs_x15, 12'd0};
                            rem_reg     <= '0;
                            divisor_reg <= d_time;
                            step_reg    <= '0;
                            state_reg   <= ST_DIV;
                        end
                        else
                            state_reg <= ST_DONE;
                        if (pop_rec.crank_ok)
                        begin
                            hist_valid_reg <= 1'b1;
                            prev_revs_reg  <= pop_rec.revs;
                            prev_time_reg  <= pop_rec.evt_time;
                        end
                        else
                            hist_valid_reg <= 1'b0;
                    end
                end
                ST_DIV:
                begin
                    quo_reg  <= quo_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        cadence_reg <= (quo_next[31:8] != 24'd0) ? CADENCE_MAX
                                                                  : quo_next[7:0];
                        state_reg   <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        res_data_reg  <= {6'd0,
                                          rec_reg.bottom_ok, rec_reg.bottom,
                                          rec_reg.top_ok, rec_reg.top,
                                          rec_reg.balance_ok, rec_reg.balance,
                                          cadence_reg, rec_reg.power};
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/cycling_power_packet_parser_top.sv
// Top level of the cycling power measurement notification parser.
// A notification enters one byte per transaction on the s_ side, with s_tlast on its final
// byte. The front collector captures the flags word, power and the optional fields by byte
// position (up to min(MAX_PACKET_BYTES, 63) bytes; later bytes are dropped) at one byte per
// cycle. After the last byte it holds s_tready low while it classifies the packet and
// pushes one record into a four-entry queue, and longer while that queue is full; packets
// under two bytes are dropped there and produce nothing. The back engine pops records in
// order, keeps the crank history and, when both crank deltas are nonzero, runs a radix-2
// restoring divider for dRevs*61440/dTime between the pop and the output load. Without a
// division a record goes from the pop straight to ST_DONE, which loads the output
// register, so the front keeps collecting bytes while a result waits. Dead spot angles
// are parsed only with angles_supported set (cfg_we/cfg_wdata, write while idle).
`include "cycling_power_packet_parser_top_defines.svh"

module cycling_power_packet_parser_top #(
    parameter int MAX_PACKET_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,     // angles_supported
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tlast,       // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] power_watts, [22:15] cadence_rpm, [30:23] balance_half_percent,
    // [31] balance_valid, [47:32] top_angle, [48] top_valid,
    // [64:49] bottom_angle, [65] bottom_valid, [71:66] zero
    output logic [cpp_pkg::OUT_W-1:0] m_tdata
);
    import cpp_pkg::*;

    logic      angles_supported_reg;
    logic      fifo_push, fifo_pop;
    rec_t      push_rec, pop_rec;
    fifo_st_t  fifo_st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angles_supported_reg <= 1'b0;
        else if (cfg_we)
            angles_supported_reg <= cfg_wdata;
    end

    cpp_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .angles_supported (angles_supported_reg),
        .byte_valid       (s_tvalid),
        .byte_ready       (s_tready),
        .byte_data        (s_tdata),
        .byte_last        (s_tlast),
        .push             (fifo_push),
        .push_rec         (push_rec),
        .fifo_st          (fifo_st)
    );

    cpp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_rec (push_rec),
        .pop      (fifo_pop),
        .pop_rec  (pop_rec),
        .st       (fifo_st)
    );

    cpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_st   (fifo_st),
        .pop_rec   (pop_rec),
        .pop       (fifo_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (m_tdata)
    );

    // Front never pushes into a full queue, back never pops an empty one.
    `CPP_ASSERT_IMP(a_push_not_full, clk, rst_n, fifo_push, !fifo_st.full)
    `CPP_ASSERT_IMP(a_pop_not_empty, clk, rst_n, fifo_pop, !fifo_st.empty)
    // A push frees the collector: it takes bytes again in the next cycle.
    `CPP_ASSERT_NXT(a_push_reopens, clk, rst_n, fifo_push, s_tready)
    // Missing balance always reports the neutral 50/50 value.
    `CPP_ASSERT_IMP(a_bal_default, clk, rst_n, m_tvalid && !m_tdata[31],
                    m_tdata[30:23] == BALANCE_DEFAULT)

endmodule

// File: tb/sv/cycling_power_packet_parser_top_tb.sv
// Self-checking testbench for the cycling power measurement notification parser.
module cycling_power_packet_parser_top_tb;

    import cpp_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int PKT_MAX      = 32;
    // collector stops storing after this many bytes of one notification
    localparam int PKT_CAP      = (PKT_MAX < 63) ? PKT_MAX : 63;
    // 1/1024 s event-time ticks per minute
    localparam int TICKS_PER_MIN = 61440;
    // covers divider, pop/load and classify, with margin
    localparam int SETTLE_CYCLES = 48;
    localparam int MAX_REPORTS   = 10;

    // One decoded measurement as it leaves the block.
    typedef struct {
        logic [14:0] power;
        logic [7:0]  cadence;
        logic [7:0]  balance;
        logic        balance_ok;
        logic [15:0] top;
        logic        top_ok;
        logic [15:0] bottom;
        logic        bottom_ok;
    } reading_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    cycling_power_packet_parser_top #(
        .MAX_PACKET_BYTES (PKT_MAX)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Parser shadow: packet collector, crank history and angle setting
    // ------------------------------------------------------------------
    logic        angles_on;
    int unsigned pkt_len;
    logic [15:0] pk_flags;
    logic [15:0] pk_power;
    logic [7:0]  pk_balance;
    logic [31:0] pk_crank;          // revs in [15:0], event time in [31:16]
    logic [15:0] pk_top;
    logic [15:0] pk_bottom;
    logic [15:0] last_revs;
    logic [15:0] last_evt;
    logic        crank_history;

    reading_t    pending_readings[$];

    // Bookkeeping
    int unsigned mismatches;
    int unsigned readings_seen;
    int unsigned packets_sent;
    int unsigned bytes_sent;
    int unsigned input_stalls;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold;

    // Transmit-side rider: keeps crank data plausible so cadence lands in range
    logic [15:0] ride_revs;
    logic [15:0] ride_evt;
    logic [7:0]  pkt_buf[$];

    function automatic void clear_collector();
        pkt_len    = 0;
        pk_flags   = '0;
        pk_power   = '0;
        pk_balance = '0;
        pk_crank   = '0;
        pk_top     = '0;
        pk_bottom  = '0;
    endfunction

    // Bytes land by position; where the optional fields sit depends on the
    // flag bits already captured.
    function automatic void capture_byte(logic [7:0] b);
        int unsigned crank_pos;
        int unsigned top_pos;
        int unsigned bot_pos;
        crank_pos = 4 + (((pk_flags & FLG_BALANCE) != 0) ? 1 : 0);
        top_pos   = crank_pos + (((pk_flags & FLG_CRANK) != 0) ? 4 : 0);
        bot_pos   = top_pos + (((pk_flags & FLG_TOP) != 0) ? 2 : 0);
        if (pkt_len < 2)
            pk_flags[8*pkt_len +: 8] = b;
        else if (pkt_len < 4)
            pk_power[8*(pkt_len-2) +: 8] = b;
        else if (((pk_flags & FLG_BALANCE) != 0) && pkt_len == 4)
            pk_balance = b;
        else
        begin
            if (pkt_len >= crank_pos && pkt_len < crank_pos + 4)
                pk_crank[8*(pkt_len-crank_pos) +: 8] = b;
            if (pkt_len >= top_pos && pkt_len < top_pos + 2)
                pk_top[8*(pkt_len-top_pos) +: 8] = b;
            if (pkt_len >= bot_pos && pkt_len < bot_pos + 2)
                pk_bottom[8*(pkt_len-bot_pos) +: 8] = b;
        end
    endfunction

    // Called for every accepted input byte; on the last byte it decodes the
    // packet and queues the reading the block must produce.
    function automatic void predict_power_reading(logic [7:0] b, logic last);
        reading_t          r;
        int unsigned       off;
        logic [15:0]       revs;
        logic [15:0]       evt;
        logic [15:0]       d_revs;
        logic [15:0]       d_evt;
        longint unsigned   rpm;
        if (pkt_len < PKT_CAP)
        begin
            capture_byte(b);
            pkt_len++;
        end
        if (!last)
            return;
        // too short to carry even the flags: dropped, history untouched
        if (pkt_len < 2)
        begin
            clear_collector();
            return;
        end
        r.power      = '0;
        r.cadence    = '0;
        r.balance    = BALANCE_DEFAULT;
        r.balance_ok = 1'b0;
        r.top        = '0;
        r.top_ok     = 1'b0;
        r.bottom     = '0;
        r.bottom_ok  = 1'b0;
        // negative power reads as zero
        if (pkt_len >= 4 && !pk_power[15])
            r.power = pk_power[14:0];
        off = 4;
        if (((pk_flags & FLG_BALANCE) != 0) && pkt_len >= off + 1)
        begin
            r.balance    = pk_balance;
            r.balance_ok = 1'b1;
            off += 1;
        end
        if (((pk_flags & FLG_CRANK) != 0) && pkt_len >= off + 4)
        begin
            revs = pk_crank[15:0];
            evt  = pk_crank[31:16];
            if (crank_history)
            begin
                d_revs = revs - last_revs;
                d_evt  = evt - last_evt;
                if (d_revs != 0 && d_evt != 0)
                begin
                    rpm = (64'(d_revs) * 64'(TICKS_PER_MIN)) / 64'(d_evt);
                    r.cadence = (rpm > 64'(CADENCE_MAX)) ? CADENCE_MAX : rpm[7:0];
                end
            end
            else
                crank_history = 1'b1;
            last_revs = revs;
            last_evt  = evt;
            off += 4;
        end
        else
            crank_history = 1'b0;   // crank missing or cut short
        if (angles_on && ((pk_flags & FLG_ANGLES) != 0))
        begin
            if (((pk_flags & FLG_TOP) != 0) && pkt_len >= off + 2)
            begin
                r.top    = pk_top;
                r.top_ok = 1'b1;
                off += 2;
            end
            if (((pk_flags & FLG_BOTTOM) != 0) && pkt_len >= off + 2)
            begin
                r.bottom    = pk_bottom;
                r.bottom_ok = 1'b1;
            end
        end
        clear_collector();
        pending_readings.push_back(r);
    endfunction

    function automatic string show_reading(reading_t r);
        return $sformatf("pwr=%0d cad=%0d bal=%0d/%0b top=%0d/%0b bot=%0d/%0b",
                         r.power, r.cadence, r.balance, r.balance_ok,
                         r.top, r.top_ok, r.bottom, r.bottom_ok);
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            #(CLK_PERIOD/2) clk = ~clk;
        end
    end

    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("timeout: %0d readings still pending", pending_readings.size());
        $display("[cycling_power_packet_parser_top] ERROR");
        $finish;
    end

    // Random gap lengths, with now and then a long pause.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Output side: ready driver (with long hold-off) and result checker
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                stall_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        reading_t    got;
        reading_t    want;
        logic [5:0]  pad;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.power      = m_tdata[14:0];
                got.cadence    = m_tdata[22:15];
                got.balance    = m_tdata[30:23];
                got.balance_ok = m_tdata[31];
                got.top        = m_tdata[47:32];
                got.top_ok     = m_tdata[48];
                got.bottom     = m_tdata[64:49];
                got.bottom_ok  = m_tdata[65];
                pad            = m_tdata[71:66];
                readings_seen++;
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected reading: %s", show_reading(got));
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.power !== want.power || got.cadence !== want.cadence ||
                        got.balance !== want.balance ||
                        got.balance_ok !== want.balance_ok ||
                        got.top !== want.top || got.top_ok !== want.top_ok ||
                        got.bottom !== want.bottom || got.bottom_ok !== want.bottom_ok ||
                        pad !== 6'd0)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("reading %0d mismatch", readings_seen);
                            $display("  expected %s", show_reading(want));
                            $display("  actual   %s pad=%0h", show_reading(got), pad);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // One byte transaction; returns at the falling edge after acceptance
    // with tvalid still high, so back-to-back bytes follow without a gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
        begin
            @(posedge clk);
            if (!s_tready)
                input_stalls++;
        end
        while (!s_tready);
        predict_power_reading(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_buf.size(); i++)
            send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
        packets_sent++;
    endtask

    function automatic void push_u16(logic [15:0] v);
        pkt_buf.push_back(v[7:0]);
        pkt_buf.push_back(v[15:8]);
    endfunction

    // Lays out a notification in field order for the given flags.
    function automatic void build_packet(logic [15:0] flags, logic [15:0] power,
                                         logic [7:0] bal, logic [15:0] revs,
                                         logic [15:0] evt, logic [15:0] top,
                                         logic [15:0] bottom);
        pkt_buf.delete();
        push_u16(flags);
        push_u16(power);
        if ((flags & FLG_BALANCE) != 0)
            pkt_buf.push_back(bal);
        if ((flags & FLG_CRANK) != 0)
        begin
            push_u16(revs);
            push_u16(evt);
        end
        if ((flags & FLG_TOP) != 0)
            push_u16(top);
        if ((flags & FLG_BOTTOM) != 0)
            push_u16(bottom);
    endfunction

    // Ends a sending phase: waits for every reading, then waits SETTLE_CYCLES more
    // before anything else happens.
    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_angles(input logic en);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        @(negedge clk);
        cfg_we    <= 1'b0;
        angles_on = en;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Short packets, power extremes, first crank packet, saturation and a
    // zero revolution delta with a wrapping event time.
    task automatic test_directed_edges();
        pkt_buf.delete();
        pkt_buf.push_back(8'hFF);                   // one byte: no reading
        send_packet();
        pkt_buf.delete();
        pkt_buf.push_back(8'h00);                   // flags only, power cut
        pkt_buf.push_back(8'h80);
        pkt_buf.push_back(8'h00);
        send_packet();
        // negative power, full balance, first crank packet
        build_packet(FLG_BALANCE | FLG_CRANK, 16'h8000, 8'hFF, 16'h0000, 16'h0000,
                     '0, '0);
        send_packet();
        // max power, 65535 revs over 65535 ticks: saturates
        build_packet(FLG_BALANCE | FLG_CRANK, 16'h7FFF, 8'h00, 16'hFFFF, 16'hFFFF,
                     '0, '0);
        send_packet();
        // no new revolution, event time wraps to delta 1
        build_packet(FLG_CRANK, 16'h0000, 8'h00, 16'hFFFF, 16'h0000, '0, '0);
        send_packet();
        drain();
    endtask

    // Dead spot angles with support on: bottom cut short, then both present.
    task automatic test_dead_spots();
        build_packet(FLG_ANGLES | FLG_TOP | FLG_BOTTOM | FLG_BALANCE, 16'd100, 8'd50,
                     '0, '0, 16'hFFFF, 16'h5A5A);
        void'(pkt_buf.pop_back());
        send_packet();
        build_packet(FLG_ANGLES | FLG_TOP | FLG_BOTTOM | FLG_CRANK, 16'd0, '0,
                     16'h1234, 16'hABCD, 16'h0000, 16'hFFFF);
        send_packet();
        drain();
    endtask

    // Mostly well-formed notifications with random content, some cut short
    // or overlong, plus raw noise.
    task automatic test_random_traffic(input int unsigned n_bytes,
                                       input int unsigned tx_pct,
                                       input int unsigned rx_pct);
        int unsigned stop_at;
        int unsigned len;
        logic [15:0] flags;
        logic [15:0] power;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                pkt_buf.delete();
                len = $urandom_range(1, 40);
                repeat (len) pkt_buf.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                flags = 16'($urandom_range(0, 65535));
                flags[0]  = ($urandom_range(0, 9) < 7);
                flags[1]  = ($urandom_range(0, 9) < 7);
                flags[8]  = ($urandom_range(0, 9) < 6);
                flags[9]  = ($urandom_range(0, 9) < 6);
                flags[10] = ($urandom_range(0, 9) < 6);
                case ($urandom_range(0, 9))
                    0:       power = 16'($urandom_range(32768, 65535));
                    1:       power = 16'($urandom_range(0, 65535));
                    default: power = 16'($urandom_range(0, 2000));
                endcase
                if ($urandom_range(0, 9) < 7)
                begin
                    ride_revs += 16'($urandom_range(0, 3));
                    ride_evt  += 16'($urandom_range(0, 2048));
                end
                else
                begin
                    ride_revs = 16'($urandom_range(0, 65535));
                    ride_evt  = 16'($urandom_range(0, 65535));
                end
                build_packet(flags, power, 8'($urandom_range(0, 255)), ride_revs,
                             ride_evt, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)));
                case ($urandom_range(0, 99)) inside
                    [0:11]:
                    begin
                        len = $urandom_range(1, pkt_buf.size() - 1);
                        while (pkt_buf.size() > len)
                            void'(pkt_buf.pop_back());
                    end
                    [12:17]:
                    begin
                        repeat ($urandom_range(1, 30))
                            pkt_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    default: ;
                endcase
            end
            send_packet();
        end
        drain();
    endtask

    // Receiver holds off for a long stretch while crank packets keep coming,
    // so the record queue and the output register fill and the input stalls.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold = 400;
        repeat (14)
        begin
            ride_revs += 16'd1;
            ride_evt  += 16'($urandom_range(600, 1400));
            build_packet(FLG_CRANK, 16'($urandom_range(0, 1500)), '0, ride_revs,
                         ride_evt, '0, '0);
            send_packet();
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        mismatches    = 0;
        readings_seen = 0;
        packets_sent  = 0;
        bytes_sent    = 0;
        input_stalls  = 0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        rx_hold       = 0;
        ride_revs     = '0;
        ride_evt      = '0;
        angles_on     = 1'b0;
        last_revs     = '0;
        last_evt      = '0;
        crank_history = 1'b0;
        clear_collector();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_directed_edges();
        write_angles(1'b1);
        test_dead_spots();
        test_random_traffic(600, 20, 20);
        write_angles(1'b0);
        test_random_traffic(500, 0, 0);
        write_angles(1'b1);
        test_backpressure();
        test_random_traffic(600, 30, 40);

        if (pending_readings.size() != 0)
        begin
            mismatches++;
            $display("%0d readings never arrived", pending_readings.size());
        end
        $display("%0d notifications (%0d bytes) sent, %0d readings checked, %0d stall cycles",
                 packets_sent, bytes_sent, readings_seen, input_stalls);
        $display("angle parsing exercised both off and on; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("[cycling_power_packet_parser_top] OK");
        else
            $display("[cycling_power_packet_parser_top] ERROR");
        $finish;
    end

endmodule
